@@ rtl/ftrs_pkg.sv @@
//------------------------------------------------------------------------------
// ftrs_pkg
// Shared types, constants and the control store of the FM tone register
// sequencer.
//------------------------------------------------------------------------------
`default_nettype none

package ftrs_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int STEP_W       = 5;

    // Command codes.
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_PLAY = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;

    // Chip register bases.
    localparam logic [7:0] BASE_MULT    = 8'h20;
    localparam logic [7:0] BASE_LEVEL   = 8'h40;
    localparam logic [7:0] BASE_ATTACK  = 8'h60;
    localparam logic [7:0] BASE_SUSTAIN = 8'h80;
    localparam logic [7:0] BASE_WAVE    = 8'hE0;
    localparam logic [7:0] BASE_FB      = 8'hC0;
    localparam logic [7:0] BASE_FNUM_LO = 8'hA0;
    localparam logic [7:0] BASE_KEY     = 8'hB0;
    localparam logic [7:0] CAR_OFFSET   = 8'd3;

    // Frequency arithmetic. A quotient by 15 is a multiply by 34953 and a
    // shift by 19, exact for every 16-bit frequency. The f-number
    // 65536 * f / 3125 is a multiply by ceil(2^40 / 3125) and a shift by 24,
    // exact for every f below F_LIMIT.
    localparam logic [15:0] RECIP_15         = 16'd34953;
    localparam int          RECIP_15_SHIFT   = 19;
    localparam logic [28:0] RECIP_FNUM       = 29'd351843721;
    localparam int          RECIP_FNUM_SHIFT = 24;
    localparam logic [15:0] F_LIMIT          = 16'd6250;

    localparam logic [2:0] MULT_LAST    = 3'd4;
    localparam logic [7:0] MULT_MAX     = 8'd15;
    localparam logic [5:0] LEVEL_MAX    = 6'd63;
    localparam logic [5:0] KEY_OFF_MASK = 6'h1F;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  channel;
        logic [15:0] frequency;
        logic [5:0]  volume;
        logic [39:0] modulator_patch;
        logic [39:0] carrier_patch;
        logic [7:0]  feedback_connection;
    } cmd_t;

    typedef struct packed {
        logic       write_valid;
        logic [7:0] reg_address;
        logic [7:0] reg_value;
        logic       status;
        logic       last;
    } res_t;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_CALC_F,
        UOP_NEXT_MULT,
        UOP_CALC_Q,
        UOP_CALC_BF,
        UOP_STORE_PATCH,
        UOP_STORE_HI
    } uop_t;

    typedef enum logic [1:0] {
        FLOW_SEQ,
        FLOW_MISS,
        FLOW_FAIL,
        FLOW_DONE
    } flow_t;

    typedef enum logic [1:0] {
        ADDR_NONE,
        ADDR_OP_MOD,
        ADDR_OP_CAR,
        ADDR_CHAN
    } addr_sel_t;

    typedef enum logic [3:0] {
        VAL_ZERO,
        VAL_MOD_BYTE,
        VAL_CAR_BYTE,
        VAL_FEEDBACK,
        VAL_MOD_MULT,
        VAL_CAR_MULT,
        VAL_LEVEL,
        VAL_FNUM_LO,
        VAL_HIGH,
        VAL_STOP
    } val_sel_t;

    typedef struct packed {
        uop_t              op;
        flow_t             flow;
        logic [STEP_W-1:0] target;
        logic              emit;
        addr_sel_t         asel;
        logic [7:0]        base;
        val_sel_t          vsel;
        logic [2:0]        byte_idx;
        logic              status;
        logic              last;
    } ucode_t;

    typedef struct packed {
        logic   start;
        logic   exec;
        ucode_t uc;
    } dp_ctl_t;

    typedef struct packed {
        logic miss;
        logic fail;
    } dp_flags_t;

    // Program entry points and jump targets.
    localparam logic [STEP_W-1:0] STEP_LOAD = 5'd0;
    localparam logic [STEP_W-1:0] STEP_PLAY = 5'd11;
    localparam logic [STEP_W-1:0] STEP_FAIL = 5'd20;
    localparam logic [STEP_W-1:0] STEP_STOP = 5'd21;

    function automatic logic [3:0] mult_of(logic [2:0] idx);
        logic [3:0] m;
        case (idx)
            3'd0:    m = 4'd1;
            3'd1:    m = 4'd2;
            3'd2:    m = 4'd4;
            3'd3:    m = 4'd8;
            default: m = 4'd15;
        endcase
        return m;
    endfunction

    // Operator slot offset of a channel: three operators per group with a
    // gap of five between groups.
    function automatic logic [4:0] op_offset(logic [2:0] ch);
        logic [4:0] ofs;
        ofs = {2'b00, ch};
        if (ch > 3'd2) ofs = ofs + 5'd5;
        if (ch > 3'd5) ofs = ofs + 5'd5;
        return ofs;
    endfunction

    function automatic ucode_t uc_word(uop_t op, flow_t flow, logic [STEP_W-1:0] target,
                                       logic emit, addr_sel_t asel, logic [7:0] base,
                                       val_sel_t vsel, logic [2:0] byte_idx,
                                       logic status, logic last);
        ucode_t w;
        w.op       = op;
        w.flow     = flow;
        w.target   = target;
        w.emit     = emit;
        w.asel     = asel;
        w.base     = base;
        w.vsel     = vsel;
        w.byte_idx = byte_idx;
        w.status   = status;
        w.last     = last;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            // Load patch: operator pairs, then the feedback register.
            5'd0:  w = uc_word(UOP_NOP, FLOW_SEQ, STEP_LOAD, 1'b1, ADDR_OP_MOD, BASE_MULT,
                               VAL_MOD_BYTE, 3'd0, 1'b0, 1'b0);
            5'd1:  w = uc_word(UOP_NOP, FLOW_SEQ, STEP_LOAD, 1'b1, ADDR_OP_CAR, BASE_MULT,
                               VAL_CAR_BYTE, 3'd0, 1'b0, 1'b0);
            5'd2:  w = uc_word(UOP_NOP, FLOW_SEQ, STEP_LOAD, 1'b1, ADDR_OP_MOD, BASE_LEVEL,
                               VAL_MOD_BYTE, 3'd1, 1'b0, 1'b0);
            5'd3:  w = uc_word(UOP_NOP, FLOW_SEQ, STEP_LOAD, 1'b1, ADDR_OP_CAR, BASE_LEVEL,
                               VAL_CAR_BYTE, 3'd1, 1'b0, 1'b0);
            5'd4:  w = uc_word(UOP_NOP, FLOW_SEQ, STEP_LOAD, 1'b1, ADDR_OP_MOD, BASE_ATTACK,
                               VAL_MOD_BYTE, 3'd2, 1'b0, 1'b0);
            5'd5:  w = uc_word(UOP_NOP, FLOW_SEQ, STEP_LOAD, 1'b1, ADDR_OP_CAR, BASE_ATTACK,
                               VAL_CAR_BYTE, 3'd2, 1'b0, 1'b0);
            5'd6:  w = uc_word(UOP_NOP, FLOW_SEQ, STEP_LOAD, 1'b1, ADDR_OP_MOD, BASE_SUSTAIN,
                               VAL_MOD_BYTE, 3'd3, 1'b0, 1'b0);
            5'd7:  w = uc_word(UOP_NOP, FLOW_SEQ, STEP_LOAD, 1'b1, ADDR_OP_CAR, BASE_SUSTAIN,
                               VAL_CAR_BYTE, 3'd3, 1'b0, 1'b0);
            5'd8:  w = uc_word(UOP_NOP, FLOW_SEQ, STEP_LOAD, 1'b1, ADDR_OP_MOD, BASE_WAVE,
                               VAL_MOD_BYTE, 3'd4, 1'b0, 1'b0);
            5'd9:  w = uc_word(UOP_NOP, FLOW_SEQ, STEP_LOAD, 1'b1, ADDR_OP_CAR, BASE_WAVE,
                               VAL_CAR_BYTE, 3'd4, 1'b0, 1'b0);
            5'd10: w = uc_word(UOP_STORE_PATCH, FLOW_DONE, STEP_LOAD, 1'b1, ADDR_CHAN, BASE_FB,
                               VAL_FEEDBACK, 3'd0, 1'b0, 1'b1);
            // Play tone: multiplier search loop, f-number, block, then writes.
            5'd11: w = uc_word(UOP_CALC_F, FLOW_SEQ, STEP_LOAD, 1'b0, ADDR_NONE, 8'h00,
                               VAL_ZERO, 3'd0, 1'b0, 1'b0);
            5'd12: w = uc_word(UOP_NEXT_MULT, FLOW_MISS, STEP_PLAY, 1'b0, ADDR_NONE, 8'h00,
                               VAL_ZERO, 3'd0, 1'b0, 1'b0);
            5'd13: w = uc_word(UOP_CALC_Q, FLOW_SEQ, STEP_LOAD, 1'b0, ADDR_NONE, 8'h00,
                               VAL_ZERO, 3'd0, 1'b0, 1'b0);
            5'd14: w = uc_word(UOP_CALC_BF, FLOW_FAIL, STEP_FAIL, 1'b0, ADDR_NONE, 8'h00,
                               VAL_ZERO, 3'd0, 1'b0, 1'b0);
            5'd15: w = uc_word(UOP_NOP, FLOW_SEQ, STEP_LOAD, 1'b1, ADDR_OP_MOD, BASE_MULT,
                               VAL_MOD_MULT, 3'd0, 1'b0, 1'b0);
            5'd16: w = uc_word(UOP_NOP, FLOW_SEQ, STEP_LOAD, 1'b1, ADDR_OP_CAR, BASE_MULT,
                               VAL_CAR_MULT, 3'd0, 1'b0, 1'b0);
            5'd17: w = uc_word(UOP_NOP, FLOW_SEQ, STEP_LOAD, 1'b1, ADDR_OP_CAR, BASE_LEVEL,
                               VAL_LEVEL, 3'd0, 1'b0, 1'b0);
            5'd18: w = uc_word(UOP_NOP, FLOW_SEQ, STEP_LOAD, 1'b1, ADDR_CHAN, BASE_FNUM_LO,
                               VAL_FNUM_LO, 3'd0, 1'b0, 1'b0);
            5'd19: w = uc_word(UOP_STORE_HI, FLOW_DONE, STEP_LOAD, 1'b1, ADDR_CHAN, BASE_KEY,
                               VAL_HIGH, 3'd0, 1'b0, 1'b1);
            5'd20: w = uc_word(UOP_NOP, FLOW_DONE, STEP_LOAD, 1'b1, ADDR_NONE, 8'h00,
                               VAL_ZERO, 3'd0, 1'b1, 1'b1);
            // Stop tone: rewrite the remembered high byte with key-on cleared.
            5'd21: w = uc_word(UOP_NOP, FLOW_DONE, STEP_LOAD, 1'b1, ADDR_CHAN, BASE_KEY,
                               VAL_STOP, 3'd0, 1'b0, 1'b1);
            default: w = uc_word(UOP_NOP, FLOW_DONE, STEP_LOAD, 1'b0, ADDR_NONE, 8'h00,
                                 VAL_ZERO, 3'd0, 1'b0, 1'b0);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ftrs_out_reg.sv @@
//------------------------------------------------------------------------------
// ftrs_out_reg
// Output register of the result channel; holds one result until it is taken.
//------------------------------------------------------------------------------
`default_nettype none

module ftrs_out_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  ftrs_pkg::res_t     push_data,
    output logic               slot_free,
    output logic               res_valid,
    input  wire logic          res_ready,
    output ftrs_pkg::res_t     res
);
    import ftrs_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t data_reg;

    assign slot_free = !valid_reg || res_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

    assign res_valid = valid_reg;
    assign res       = data_reg;

endmodule

`default_nettype wire

@@ rtl/ftrs_sequencer.sv @@
//------------------------------------------------------------------------------
// ftrs_sequencer
// Step counter and control store; dispatches a command to its program and
// steps through it, holding on result steps while the output is full.
//------------------------------------------------------------------------------
`default_nettype none

module ftrs_sequencer #(
    parameter int CHANNELS = ftrs_pkg::CHANNELS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire logic [1:0]    action,
    input  wire logic [2:0]    channel,
    input  ftrs_pkg::dp_flags_t flags,
    input  wire logic          slot_free,
    output ftrs_pkg::dp_ctl_t  ctl,
    output logic               push
);
    import ftrs_pkg::*;

    localparam logic [3:0] CHAN_LIMIT = 4'(CHANNELS);

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] entry;
    logic              cmd_ok;
    logic              accept;
    logic              adv;
    ucode_t            uc;

    assign uc        = ucode_rom(step_reg);
    assign cmd_ready = !busy_reg;
    assign accept    = cmd_valid && cmd_ready;
    // A result step waits until the output register can take the result.
    assign adv       = busy_reg && (!uc.emit || slot_free);
    assign push      = adv && uc.emit;

    always_comb
    begin
        entry  = STEP_LOAD;
        cmd_ok = ({1'b0, channel} < CHAN_LIMIT);
        case (action)
            ACT_LOAD: entry = STEP_LOAD;
            ACT_PLAY: entry = STEP_PLAY;
            ACT_STOP: entry = STEP_STOP;
            default:  cmd_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept)
        begin
            busy_next = cmd_ok;
            step_next = entry;
        end
        else if (adv)
        begin
            case (uc.flow)
                FLOW_SEQ:  step_next = step_reg + 1'b1;
                FLOW_MISS: step_next = flags.miss ? uc.target : step_reg + 1'b1;
                FLOW_FAIL: step_next = flags.fail ? uc.target : step_reg + 1'b1;
                FLOW_DONE: busy_next = 1'b0;
                default:   busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_LOAD;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign ctl.start = accept;
    assign ctl.exec  = adv;
    assign ctl.uc    = uc;

endmodule

`default_nettype wire

@@ rtl/ftrs_datapath.sv @@
//------------------------------------------------------------------------------
// ftrs_datapath
// Command register, per-channel tone state, frequency arithmetic and result
// formatting, all driven by the current control word.
//------------------------------------------------------------------------------
`default_nettype none

module ftrs_datapath #(
    parameter int CHANNELS = ftrs_pkg::CHANNELS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  ftrs_pkg::cmd_t      cmd,
    input  ftrs_pkg::dp_ctl_t   ctl,
    output ftrs_pkg::dp_flags_t flags,
    output ftrs_pkg::res_t      result
);
    import ftrs_pkg::*;

    localparam int ENTRIES = (CHANNELS > 8) ? 8 : CHANNELS;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    cmd_t        cmd_reg;
    logic [2:0]  midx_reg;
    logic [2:0]  midx_next;
    logic [15:0] f_reg;
    logic [16:0] q_reg;
    logic [2:0]  blk_reg;
    logic [9:0]  fnum_reg;

    logic [1:0]  ksl_reg   [ENTRIES];
    logic [7:0]  mchar_reg [ENTRIES];
    logic [7:0]  cchar_reg [ENTRIES];
    logic [5:0]  hi_reg    [ENTRIES];

    logic [IDX_W-1:0] idx;
    logic [1:0]  ksl_cur;
    logic [7:0]  mchar_cur;
    logic [7:0]  cchar_cur;
    logic [5:0]  hi_cur;
    logic [3:0]  mult;
    logic [7:0]  m_mult;
    logic [7:0]  c_mult;
    logic [31:0] prod15;
    logic [15:0] f_calc;
    logic [41:0] prod_q;
    logic [16:0] q_calc;
    logic [2:0]  blk_calc;
    logic [9:0]  fnum_calc;
    logic [5:0]  hi_new;
    logic [4:0]  ofs;
    logic [5:0]  shamt;
    logic [7:0]  mod_byte;
    logic [7:0]  car_byte;
    logic        f_over;

    assign idx       = cmd_reg.channel[IDX_W-1:0];
    assign ksl_cur   = ksl_reg[idx];
    assign mchar_cur = mchar_reg[idx];
    assign cchar_cur = cchar_reg[idx];
    assign hi_cur    = hi_reg[idx];

    assign mult   = mult_of(midx_reg);
    assign m_mult = {4'b0000, mchar_cur[3:0]} * {4'b0000, mult};
    assign c_mult = {4'b0000, cchar_cur[3:0]} * {4'b0000, mult};

    assign prod15 = 32'(cmd_reg.frequency) * 32'(RECIP_15);
    assign f_calc = (midx_reg == MULT_LAST) ? 16'(prod15 >> RECIP_15_SHIFT)
                                            : (cmd_reg.frequency >> midx_reg[1:0]);

    // A frequency at or above F_LIMIT here fails at the block step anyway,
    // so 13 bits suffice for every result that is used.
    assign prod_q = 42'(f_reg[12:0]) * 42'(RECIP_FNUM);
    assign q_calc = 17'(prod_q >> RECIP_FNUM_SHIFT);

    // Block is the number of halvings that bring the f-number under 1024.
    always_comb
    begin
        blk_calc = 3'd0;
        for (int b = 1; b < 8; b++)
        begin
            if (q_reg[9 + b])
            begin
                blk_calc = 3'(b);
            end
        end
    end

    assign fnum_calc = 10'(q_reg >> blk_calc);
    assign hi_new    = {1'b1, blk_reg, fnum_reg[9:8]};

    // The search stops at the last multiplier; a frequency still too high
    // there is a failure.
    assign f_over     = (f_reg >= F_LIMIT);
    assign flags.miss = f_over && (midx_reg != MULT_LAST);
    assign flags.fail = f_over || (m_mult > MULT_MAX) || (c_mult > MULT_MAX);

    always_comb
    begin
        midx_next = midx_reg;
        if (ctl.start)
        begin
            midx_next = 3'd0;
        end
        else if (ctl.exec && (ctl.uc.op == UOP_NEXT_MULT) && flags.miss)
        begin
            midx_next = midx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            midx_reg <= 3'd0;
        end
        else
        begin
            midx_reg <= midx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            cmd_reg <= cmd;
        end
        if (ctl.exec)
        begin
            case (ctl.uc.op)
                UOP_CALC_F: f_reg <= f_calc;
                UOP_CALC_Q: q_reg <= q_calc;
                UOP_CALC_BF:
                begin
                    blk_reg  <= blk_calc;
                    fnum_reg <= fnum_calc;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                ksl_reg[i]   <= 2'b00;
                mchar_reg[i] <= 8'h00;
                cchar_reg[i] <= 8'h00;
                hi_reg[i]    <= 6'h00;
            end
        end
        else if (ctl.exec)
        begin
            case (ctl.uc.op)
                UOP_STORE_PATCH:
                begin
                    ksl_reg[idx]   <= cmd_reg.carrier_patch[31:30];
                    mchar_reg[idx] <= cmd_reg.modulator_patch[39:32];
                    cchar_reg[idx] <= cmd_reg.carrier_patch[39:32];
                end
                UOP_STORE_HI: hi_reg[idx] <= hi_new;
                default: ;
            endcase
        end
    end

    // Patch bytes are numbered from the high end.
    assign shamt    = 6'd32 - {ctl.uc.byte_idx, 3'b000};
    assign mod_byte = 8'(cmd_reg.modulator_patch >> shamt);
    assign car_byte = 8'(cmd_reg.carrier_patch >> shamt);
    assign ofs      = op_offset(cmd_reg.channel);

    always_comb
    begin
        result.write_valid = (ctl.uc.asel != ADDR_NONE);
        result.status      = ctl.uc.status;
        result.last        = ctl.uc.last;

        case (ctl.uc.asel)
            ADDR_OP_MOD: result.reg_address = ctl.uc.base + {3'b000, ofs};
            ADDR_OP_CAR: result.reg_address = ctl.uc.base + {3'b000, ofs} + CAR_OFFSET;
            ADDR_CHAN:   result.reg_address = ctl.uc.base + {5'b00000, cmd_reg.channel};
            default:     result.reg_address = 8'h00;
        endcase

        case (ctl.uc.vsel)
            VAL_MOD_BYTE: result.reg_value = mod_byte;
            VAL_CAR_BYTE: result.reg_value = car_byte;
            VAL_FEEDBACK: result.reg_value = cmd_reg.feedback_connection;
            VAL_MOD_MULT: result.reg_value = {mchar_cur[7:4], m_mult[3:0]};
            VAL_CAR_MULT: result.reg_value = {cchar_cur[7:4], c_mult[3:0]};
            VAL_LEVEL:    result.reg_value = {ksl_cur, LEVEL_MAX - cmd_reg.volume};
            VAL_FNUM_LO:  result.reg_value = fnum_reg[7:0];
            VAL_HIGH:     result.reg_value = {2'b00, hi_new};
            VAL_STOP:     result.reg_value = {2'b00, hi_cur & KEY_OFF_MASK};
            default:      result.reg_value = 8'h00;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/fm_tone_register_sequencer_unit.sv @@
//------------------------------------------------------------------------------
// fm_tone_register_sequencer_unit
// Turns FM synth channel commands into ordered chip register writes.
//------------------------------------------------------------------------------
// Usage:
//   cmd_valid/cmd_ready/cmd carry one command request: load patch, play tone
//   or stop tone for one channel. res_valid/res_ready/res carry the results,
//   one register write each (or a single failure result for play), with
//   last set on the final result of a command.
//   The block works on one command at a time; cmd_ready is high only when the
//   previous command has handed its last result to the output register.
//   A microprogram steps one control word per cycle, holding on a result
//   step while the output register is full. Load patch makes 11 writes,
//   stop tone 1. Play tone tries 1 to 5 multipliers, then works out the
//   f-number and block and makes 5 writes.
//   A command for a channel at or above CHANNELS, or an unknown action, is
//   taken and dropped with no result.
//   Reset empties the output register, idles the sequencer and clears all
//   per-channel tone state. A stalled receiver holds the current result in
//   the output register and the program waits on its next result step.
//------------------------------------------------------------------------------
`default_nettype none

module fm_tone_register_sequencer_unit #(
    parameter int CHANNELS = ftrs_pkg::CHANNELS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  ftrs_pkg::cmd_t cmd,
    output logic           res_valid,
    input  wire logic      res_ready,
    output ftrs_pkg::res_t res
);
    import ftrs_pkg::*;

    dp_ctl_t   ctl;
    dp_flags_t flags;
    res_t      result;
    logic      push;
    logic      slot_free;

    ftrs_sequencer #(
        .CHANNELS (CHANNELS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .action    (cmd.action),
        .channel   (cmd.channel),
        .flags     (flags),
        .slot_free (slot_free),
        .ctl       (ctl),
        .push      (push)
    );

    ftrs_datapath #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ctl    (ctl),
        .flags  (flags),
        .result (result)
    );

    ftrs_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

`default_nettype wire

@@ rtl/ftrs_checker.sv @@
//------------------------------------------------------------------------------
// ftrs_checker
// Port-level checks of the FM tone register sequencer, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module ftrs_checker (
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     cmd_valid,
    input wire logic     cmd_ready,
    input ftrs_pkg::cmd_t cmd,
    input wire logic     res_valid,
    input wire logic     res_ready,
    input ftrs_pkg::res_t res
);
    import ftrs_pkg::*;

    // A stalled result stays put.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // A result without a write is the play failure result and nothing else.
    a_no_write_is_failure: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.write_valid |->
            res.status && res.last && (res.reg_address == 8'h00) &&
            (res.reg_value == 8'h00))
        else $error("result without a write is not a failure result");

    // A failure status never comes with a write.
    a_failure_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status |-> !res.write_valid)
        else $error("failure result carries a write");

    // While a command still has results to come, no new request is taken.
    a_busy_mid_command: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.last |-> !cmd_ready)
        else $error("request taken in the middle of a command");

    // Channel zero always exists, so a load on it keeps the block busy.
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd.action == ACT_LOAD) && (cmd.channel == 3'd0)
            |=> !cmd_ready)
        else $error("load request did not start a program");

endmodule

bind fm_tone_register_sequencer_unit ftrs_checker u_ftrs_checker (.*);

`default_nettype wire
